[sv/ptrt_pkg.sv]
// Shared types, constants and helper functions for the pose to rigid transform block.
// Has no dependencies. Every other file refers to it by scoped names.
package ptrt_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam int ANGLE_W      = 17;
   localparam int XY_W         = 33;
   localparam int Z_W          = 25;
   localparam int ATAN_W       = 23;
   localparam int TRIG_W       = 22;
   localparam int MID_DEPTH    = 2;

   localparam logic signed [ANGLE_W-1:0] DEG90  = 17'sd11520;
   localparam logic signed [ANGLE_W-1:0] DEG180 = 17'sd23040;
   localparam logic signed [ANGLE_W-1:0] DEG360 = 17'sd46080;
   localparam logic signed [XY_W-1:0]    GAIN_Q30 = 33'sd652032874;
   localparam logic signed [TRIG_W-1:0]  ONE_Q20  = 22'sd1048576;

   localparam logic [1:0] ROW_0 = 2'd0;
   localparam logic [1:0] ROW_1 = 2'd1;
   localparam logic [1:0] ROW_2 = 2'd2;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
   } req_type;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [15:0] col0;
      logic signed [15:0] col1;
      logic signed [15:0] col2;
      logic signed [31:0] col3_offset;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
   } offset_type;

   // sine and cosine of the three angles at scale 2^20, with the pose offsets
   typedef struct packed {
      logic signed [TRIG_W-1:0] sr;
      logic signed [TRIG_W-1:0] cr;
      logic signed [TRIG_W-1:0] sy;
      logic signed [TRIG_W-1:0] cy;
      logic signed [TRIG_W-1:0] sp;
      logic signed [TRIG_W-1:0] cp;
      offset_type               offs;
   } trig_type;

   // atan(2^-i) in degrees times 2^16
   function automatic logic signed [ATAN_W-1:0] atan_deg16(input int idx);
      logic signed [ATAN_W-1:0] r;
      case (idx)
         0:  r = 23'sd2949120;
         1:  r = 23'sd1740967;
         2:  r = 23'sd919879;
         3:  r = 23'sd466945;
         4:  r = 23'sd234379;
         5:  r = 23'sd117304;
         6:  r = 23'sd58666;
         7:  r = 23'sd29335;
         8:  r = 23'sd14668;
         9:  r = 23'sd7334;
         10: r = 23'sd3667;
         11: r = 23'sd1833;
         12: r = 23'sd917;
         13: r = 23'sd458;
         14: r = 23'sd229;
         15: r = 23'sd115;
         16: r = 23'sd57;
         17: r = 23'sd29;
         18: r = 23'sd14;
         19: r = 23'sd7;
         20: r = 23'sd4;
         21: r = 23'sd2;
         22: r = 23'sd1;
         default: r = 23'sd0;
      endcase
      return r;
   endfunction

   // round half up by a right shift, then clamp to Q2.14
   function automatic logic signed [15:0] round_sat(input logic signed [66:0] v,
                                                    input int sh);
      logic signed [66:0] r;
      logic signed [15:0] q;
      r = (v + (67'sd1 <<< (sh - 1))) >>> sh;
      if (r > 67'sd32767) begin
         q = 16'sh7fff;
      end else if (r < -67'sd32768) begin
         q = 16'sh8000;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

endpackage

[sv/ptrt_front.sv]
// Front part: accepts poses, folds each angle into [-90, 90] degrees and runs
// three pipelined CORDIC lanes. Depends on ptrt_pkg.
module ptrt_front #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  ptrt_pkg::req_type  req_data,
   output logic               req_full,
   output logic               trig_push,
   output ptrt_pkg::trig_type trig_data,
   input  logic               trig_full
);

   localparam int STEPS = (CORDIC_STEPS > ptrt_pkg::ATAN_ENTRIES) ?
                          ptrt_pkg::ATAN_ENTRIES : CORDIC_STEPS;
   localparam int XW = ptrt_pkg::XY_W;
   localparam int ZW = ptrt_pkg::Z_W;

   logic [STEPS:0]                 valid_ff;
   logic signed [XW-1:0]           x_ff   [0:STEPS][0:2];
   logic signed [XW-1:0]           y_ff   [0:STEPS][0:2];
   logic signed [ZW-1:0]           z_ff   [0:STEPS][0:2];
   logic [2:0]                     neg_ff [0:STEPS];
   ptrt_pkg::offset_type           offs_ff[0:STEPS];

   logic                           advance;
   logic                           accept;
   logic signed [15:0]             angle_in [0:2];
   logic signed [ZW-1:0]           z_in     [0:2];
   logic [2:0]                     neg_in;
   logic signed [XW-1:0]           cos_res  [0:2];
   logic signed [XW-1:0]           sin_res  [0:2];
   logic signed [XW:0]             cos_rnd  [0:2];
   logic signed [XW:0]             sin_rnd  [0:2];

   // stall the whole pipeline while the last stage cannot hand off
   assign advance  = !(valid_ff[STEPS] && trig_full);
   assign req_full = !advance;
   assign accept   = req_push && advance;

   // fold each angle into [-180, 180) and then into [-90, 90]
   always_comb begin
      logic signed [ptrt_pkg::ANGLE_W-1:0] w;
      angle_in[0] = req_data.roll_angle;
      angle_in[1] = req_data.yaw_angle;
      angle_in[2] = req_data.pitch_angle;
      for (int l = 0; l < 3; l++) begin
         w = ptrt_pkg::ANGLE_W'(angle_in[l]);
         if (w >= ptrt_pkg::DEG180) begin
            w = w - ptrt_pkg::DEG360;
         end else if (w < -ptrt_pkg::DEG180) begin
            w = w + ptrt_pkg::DEG360;
         end
         neg_in[l] = 1'b0;
         if (w > ptrt_pkg::DEG90) begin
            w = w - ptrt_pkg::DEG180;
            neg_in[l] = 1'b1;
         end else if (w < -ptrt_pkg::DEG90) begin
            w = w + ptrt_pkg::DEG180;
            neg_in[l] = 1'b1;
         end
         z_in[l] = ZW'(w) <<< 9;
      end
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STEPS-1:0], accept};
      end
   end

   // load the first stage
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[0][l] <= ptrt_pkg::GAIN_Q30;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= z_in[l];
         end
         neg_ff[0]           <= neg_in;
         offs_ff[0].offset_x <= req_data.offset_x;
         offs_ff[0].offset_y <= req_data.offset_y;
         offs_ff[0].offset_z <= req_data.offset_z;
      end
   end

   // one CORDIC micro-rotation per stage
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int l = 0; l < 3; l++) begin
               if (z_ff[k-1][l] >= 0) begin
                  x_ff[k][l] <= x_ff[k-1][l] - (y_ff[k-1][l] >>> (k - 1));
                  y_ff[k][l] <= y_ff[k-1][l] + (x_ff[k-1][l] >>> (k - 1));
                  z_ff[k][l] <= z_ff[k-1][l] - ZW'(ptrt_pkg::atan_deg16(k - 1));
               end else begin
                  x_ff[k][l] <= x_ff[k-1][l] + (y_ff[k-1][l] >>> (k - 1));
                  y_ff[k][l] <= y_ff[k-1][l] - (x_ff[k-1][l] >>> (k - 1));
                  z_ff[k][l] <= z_ff[k-1][l] + ZW'(ptrt_pkg::atan_deg16(k - 1));
               end
            end
            neg_ff[k]  <= neg_ff[k-1];
            offs_ff[k] <= offs_ff[k-1];
         end
      end
   end

   // undo the half-turn fold and round to scale 2^20
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cos_res[l] = neg_ff[STEPS][l] ? -x_ff[STEPS][l] : x_ff[STEPS][l];
         sin_res[l] = neg_ff[STEPS][l] ? -y_ff[STEPS][l] : y_ff[STEPS][l];
         cos_rnd[l] = ((XW + 1)'(cos_res[l]) + (XW + 1)'(512)) >>> 10;
         sin_rnd[l] = ((XW + 1)'(sin_res[l]) + (XW + 1)'(512)) >>> 10;
      end
      trig_data.sr   = sin_rnd[0][ptrt_pkg::TRIG_W-1:0];
      trig_data.cr   = cos_rnd[0][ptrt_pkg::TRIG_W-1:0];
      trig_data.sy   = sin_rnd[1][ptrt_pkg::TRIG_W-1:0];
      trig_data.cy   = cos_rnd[1][ptrt_pkg::TRIG_W-1:0];
      trig_data.sp   = sin_rnd[2][ptrt_pkg::TRIG_W-1:0];
      trig_data.cp   = cos_rnd[2][ptrt_pkg::TRIG_W-1:0];
      trig_data.offs = offs_ff[STEPS];
   end

   assign trig_push = valid_ff[STEPS] && !trig_full;

   // a stalled last stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STEPS] && !advance) |=> valid_ff[STEPS])
      else $error("front dropped a stalled item");

   // an accepted pose enters the first stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff[0])
      else $error("front lost an accepted pose");

   // the front only reports full while its last stage waits
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> (valid_ff[STEPS] && trig_full))
      else $error("front full without a waiting item");

endmodule

[sv/ptrt_queue.sv]
// Short queue of sine/cosine sets between the front and back parts.
// Depends on ptrt_pkg.
module ptrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ptrt_pkg::trig_type push_data,
   output logic               full,
   input  logic               pop,
   output ptrt_pkg::trig_type head_data,
   output logic               empty
);

   localparam int DEPTH = ptrt_pkg::MID_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   ptrt_pkg::trig_type  mem_ff [0:DEPTH-1];
   logic [PW-1:0]       head_ff;
   logic [PW-1:0]       tail_ff;
   logic [PW:0]         count_ff;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == (PW + 1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = mem_ff[head_ff];

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff <= (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (do_pop) begin
            head_ff <= (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         count_ff <= count_ff + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW + 1)'(DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count missed a pop");

endmodule

[sv/ptrt_back.sv]
// Back part: forms one matrix row per unstalled cycle from a sine/cosine set
// with pipelined products, rounds and clamps to Q2.14. Depends on ptrt_pkg.
module ptrt_back (
   input  logic               clock,
   input  logic               reset,
   input  ptrt_pkg::trig_type head_data,
   input  logic               head_empty,
   output logic               head_pop,
   output ptrt_pkg::rsp_type  rsp_data,
   output logic               rsp_empty,
   input  logic               rsp_pop
);

   localparam int TW = ptrt_pkg::TRIG_W;

   logic [1:0]              row_ff;
   logic                    advance;
   logic                    issue;
   logic [4:1]              valid_ff;

   logic signed [TW-1:0]    a0_c, f0_c, ta_c, b_c, v1_c, v2_c;
   logic signed [31:0]      off_c;

   logic [1:0]              row1_ff, row2_ff, row3_ff, row4_ff;
   logic signed [31:0]      off1_ff, off2_ff, off3_ff, off4_ff;
   logic signed [2*TW-1:0]  m0_1_ff, m0_2_ff, m0_3_ff, m0_4_ff;
   logic signed [2*TW-1:0]  t1_ff, u1_1_ff, u2_1_ff, u1_2_ff, u2_2_ff, u1_3_ff, u2_3_ff;
   logic signed [TW-1:0]    s1_ff, c1_ff;
   logic signed [TW:0]      th_c;
   logic signed [TW-1:0]    tl_c;
   logic signed [2*TW:0]    ph1_ff, ph2_ff;
   logic signed [2*TW-1:0]  pl1_ff, pl2_ff;
   logic signed [65:0]      tr1_ff, tr2_ff;
   logic signed [66:0]      e1_ff, e2_ff;

   ptrt_pkg::rsp_type       rsp_ff;
   logic                    rsp_valid_ff;

   // the whole row pipeline moves when the output register can take an item
   assign advance   = !rsp_valid_ff || rsp_pop;
   assign issue     = advance && !head_empty;
   assign head_pop  = issue && (row_ff == ptrt_pkg::ROW_2);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pick the factors of the current row
   always_comb begin
      unique case (row_ff)
         ptrt_pkg::ROW_0: begin
            a0_c  = head_data.cy;  f0_c = head_data.cp;  ta_c = head_data.cy;
            b_c   = -head_data.sy; v1_c = head_data.cr;  v2_c = head_data.sr;
            off_c = head_data.offs.offset_x;
         end
         ptrt_pkg::ROW_1: begin
            a0_c  = head_data.sy;  f0_c = head_data.cp;  ta_c = head_data.sy;
            b_c   = head_data.cy;  v1_c = head_data.cr;  v2_c = head_data.sr;
            off_c = head_data.offs.offset_y;
         end
         ptrt_pkg::ROW_2: begin
            a0_c  = head_data.sp;  f0_c = ptrt_pkg::ONE_Q20; ta_c = '0;
            b_c   = head_data.cp;  v1_c = -head_data.sr; v2_c = head_data.cr;
            off_c = head_data.offs.offset_z;
         end
         default: begin
            a0_c  = '0; f0_c = '0; ta_c = '0;
            b_c   = '0; v1_c = '0; v2_c = '0;
            off_c = '0;
         end
      endcase
   end

   // step through the three rows of a set
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= ptrt_pkg::ROW_0;
      end else if (issue) begin
         row_ff <= (row_ff == ptrt_pkg::ROW_2) ? ptrt_pkg::ROW_0 : row_ff + 1'b1;
      end
   end

   // advance valid bits and the output register flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[3:1], issue};
         rsp_valid_ff <= valid_ff[4];
      end
   end

   // split the pair product for the triple terms
   assign th_c = t1_ff[2*TW-1:TW-1];
   assign tl_c = {1'b0, t1_ff[TW-2:0]};

   // product and sum pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         row1_ff <= row_ff;
         off1_ff <= off_c;
         m0_1_ff <= a0_c * f0_c;
         t1_ff   <= ta_c * head_data.sp;
         u1_1_ff <= b_c * v1_c;
         u2_1_ff <= b_c * v2_c;
         s1_ff   <= head_data.sr;
         c1_ff   <= head_data.cr;

         row2_ff <= row1_ff;
         off2_ff <= off1_ff;
         m0_2_ff <= m0_1_ff;
         u1_2_ff <= u1_1_ff;
         u2_2_ff <= u2_1_ff;
         ph1_ff  <= th_c * s1_ff;
         pl1_ff  <= tl_c * s1_ff;
         ph2_ff  <= th_c * c1_ff;
         pl2_ff  <= tl_c * c1_ff;

         row3_ff <= row2_ff;
         off3_ff <= off2_ff;
         m0_3_ff <= m0_2_ff;
         u1_3_ff <= u1_2_ff;
         u2_3_ff <= u2_2_ff;
         tr1_ff  <= (66'(ph1_ff) <<< (TW - 1)) + 66'(pl1_ff);
         tr2_ff  <= (66'(ph2_ff) <<< (TW - 1)) + 66'(pl2_ff);

         row4_ff <= row3_ff;
         off4_ff <= off3_ff;
         m0_4_ff <= m0_3_ff;
         e1_ff   <= 67'(tr1_ff) + (67'(u1_3_ff) <<< 20);
         e2_ff   <= (67'(u2_3_ff) <<< 20) - 67'(tr2_ff);

         rsp_ff.row_index   <= row4_ff;
         rsp_ff.col0        <= ptrt_pkg::round_sat(67'(m0_4_ff), 26);
         rsp_ff.col1        <= ptrt_pkg::round_sat(e1_ff, 46);
         rsp_ff.col2        <= ptrt_pkg::round_sat(e2_ff, 46);
         rsp_ff.col3_offset <= off4_ff;
         rsp_ff.last_row    <= (row4_ff == ptrt_pkg::ROW_2);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      row_ff != 2'd3)
      else $error("row counter out of range");

   assert property (@(posedge clock) disable iff (reset)
      head_pop |=> (row_ff == ptrt_pkg::ROW_0))
      else $error("set released before its last row");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last_row == (rsp_ff.row_index == ptrt_pkg::ROW_2)))
      else $error("last_row flag mismatches row index");

endmodule

[sv/pose_to_rigid_transform.sv]
// Top level of the pose to rigid transform block.
// Instantiates ptrt_front, ptrt_queue and ptrt_back; uses ptrt_pkg.
//
// Use:
//   Input channel: drive req_data and raise req_push; a pose is taken at a
//   clock edge with req_push high and req_full low. Each pose holds three
//   Q16.16 offsets and roll, yaw, pitch in degrees with 7 fraction bits.
//   Result channel: while rsp_empty is low, rsp_data holds the oldest row
//   item; raise rsp_pop to take it. Each pose gives three items, rows 0, 1
//   and 2, with last_row set on row 2.
//   Rate: the row unit forms one matrix row per cycle while a sine/cosine
//   set waits and the receiver is not stalling, so each pose occupies it
//   for three rows; the CORDIC pipeline takes one pose per cycle while
//   req_full is low.
//   Reset (synchronous, active high) empties every stage and the queue;
//   no clearing pass is needed.
//   When the receiver stalls, the row pipeline holds, the middle queue fills
//   with up to two sine/cosine sets, then the CORDIC pipeline holds and
//   req_full rises. No item is lost or repeated.
module pose_to_rigid_transform #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  ptrt_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ptrt_pkg::rsp_type rsp_data
);

   ptrt_pkg::trig_type trig_in;
   ptrt_pkg::trig_type trig_head;
   logic               trig_push;
   logic               trig_full;
   logic               trig_pop;
   logic               trig_empty;

   ptrt_front #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .trig_push (trig_push),
      .trig_data (trig_in),
      .trig_full (trig_full)
   );

   ptrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (trig_push),
      .push_data (trig_in),
      .full      (trig_full),
      .pop       (trig_pop),
      .head_data (trig_head),
      .empty     (trig_empty)
   );

   ptrt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (trig_head),
      .head_empty (trig_empty),
      .head_pop   (trig_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule
